>>> rtl/fircd_pkg.sv
// shared constants and types for the circular-delay fir filter
package fircd_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS       = 16;
    localparam int FRAC_BITS       = 15;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index of active_taps
    localparam logic REG_ACTIVE_TAPS = 1'b0;

    // item kinds on the input channel
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // status from the compute engine
    typedef struct packed {
        logic busy;
        logic load;
    } fircd_stat_t;

endpackage

>>> rtl/fircd_front.sv
// input stage: accepts items, drops bad tap writes, queues work for the engine
module fircd_front #(
    parameter int MAX_TAPS    = fircd_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fircd_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_TAPS)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  logic        [IDX_W-1:0]              s_tap_index,
    input  logic signed [fircd_pkg::COEF_BITS-1:0] s_tap_value,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output logic                                 q_is_coef,
    output logic signed [SAMPLE_BITS-1:0]        q_sample,
    output logic        [IDX_W-1:0]              q_tap_index,
    output logic signed [fircd_pkg::COEF_BITS-1:0] q_tap_value
);
    import fircd_pkg::*;

    logic                        coef_reg   [2];
    logic signed [SAMPLE_BITS-1:0] sample_reg [2];
    logic        [IDX_W-1:0]     idx_reg    [2];
    logic signed [COEF_BITS-1:0] value_reg  [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    logic       pop;

    assign s_ready = (count_reg != 2'd2);
    // tap writes beyond the built tap count are taken and thrown away
    assign keep = (s_kind == KIND_SAMPLE) ||
                  ({1'b0, s_tap_index} < (IDX_W + 1)'(MAX_TAPS));
    assign push = s_valid && s_ready && keep;
    assign pop  = q_valid && q_ready;

    assign q_valid     = (count_reg != 2'd0);
    assign q_is_coef   = coef_reg[rd_ptr_reg];
    assign q_sample    = sample_reg[rd_ptr_reg];
    assign q_tap_index = idx_reg[rd_ptr_reg];
    assign q_tap_value = value_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            coef_reg[wr_ptr_reg]   <= (s_kind == KIND_COEF);
            sample_reg[wr_ptr_reg] <= s_sample;
            idx_reg[wr_ptr_reg]    <= s_tap_index;
            value_reg[wr_ptr_reg]  <= s_tap_value;
        end
    end

endmodule

>>> rtl/fircd_back.sv
// compute engine: delay line and tap memories, shared multiply-accumulate, output register
module fircd_back #(
    parameter int MAX_TAPS    = fircd_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fircd_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_TAPS),
    localparam int AT_W       = $clog2(MAX_TAPS + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [AT_W-1:0]                      active_taps,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  logic                                 q_is_coef,
    input  logic signed [SAMPLE_BITS-1:0]        q_sample,
    input  logic        [IDX_W-1:0]              q_tap_index,
    input  logic signed [fircd_pkg::COEF_BITS-1:0] q_tap_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_filtered,
    output logic                                 m_clipped,
    output fircd_pkg::fircd_stat_t               stat
);
    import fircd_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam int RES_W  = ACC_W - FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   taps_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           hist_vld_reg;
    logic [MAX_TAPS-1:0]           taps_vld_reg;

    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [IDX_W-1:0] rp_reg, rp_next;
    logic [IDX_W-1:0] tj_reg, tj_next;
    logic [AT_W-1:0]  cnt_reg, cnt_next;
    logic [AT_W-1:0]  n_eff;

    logic                          rd_vld_reg;
    logic signed [SAMPLE_BITS-1:0] hist_rd_reg;
    logic signed [COEF_BITS-1:0]   taps_rd_reg;
    logic                          hv_reg;
    logic                          tv_reg;
    logic signed [SAMPLE_BITS-1:0] hist_op;
    logic signed [COEF_BITS-1:0]   taps_op;

    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [ACC_W-1:0]       rounded;
    logic signed [RES_W-1:0]       res;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    logic m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic clipped_reg;

    logic start_smp;
    logic start_coef;
    logic issue;
    logic load;

    assign q_ready    = (state_reg == ST_IDLE);
    assign start_smp  = q_valid && q_ready && !q_is_coef;
    assign start_coef = q_valid && q_ready && q_is_coef;
    assign issue      = (state_reg == ST_RUN);
    assign load       = (state_reg == ST_DRAIN) && !rd_vld_reg && !prod_vld_reg &&
                        (!m_valid_reg || m_ready);

    // zero taps acts as one, more than built acts as all
    always_comb begin
        if (active_taps == '0) begin
            n_eff = AT_W'(1);
        end else if (active_taps > AT_W'(MAX_TAPS)) begin
            n_eff = AT_W'(MAX_TAPS);
        end else begin
            n_eff = active_taps;
        end
    end

    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        tj_next    = tj_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_smp) begin
                    rp_next    = wp_reg;
                    tj_next    = '0;
                    cnt_next   = n_eff;
                    wp_next    = (wp_reg == IDX_W'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // walk back through the delay line, forward through the taps
                rp_next  = (rp_reg == '0) ? IDX_W'(MAX_TAPS - 1) : rp_reg - 1'b1;
                tj_next  = tj_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == AT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            tj_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            tj_reg    <= tj_next;
            cnt_reg   <= cnt_next;
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            taps_vld_reg <= '0;
        end else begin
            if (start_smp) begin
                hist_vld_reg[wp_reg] <= 1'b1;
            end
            if (start_coef) begin
                taps_vld_reg[q_tap_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_smp) begin
            hist_mem[wp_reg] <= q_sample;
        end
        if (issue) begin
            hist_rd_reg <= hist_mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (start_coef) begin
            taps_mem[q_tap_index] <= q_tap_value;
        end
        if (issue) begin
            taps_rd_reg <= taps_mem[tj_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            hv_reg <= hist_vld_reg[rp_reg];
            tv_reg <= taps_vld_reg[tj_reg];
        end
    end

    assign hist_op = hv_reg ? hist_rd_reg : '0;
    assign taps_op = tv_reg ? taps_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= PROD_W'(hist_op) * PROD_W'(taps_op);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (start_smp) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // round half up from q1.15, then saturate
    assign rounded = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign res     = RES_W'(rounded >>> FRAC_BITS);
    assign ovf     = (res[RES_W-1:SAMPLE_BITS-1] != '0) &&
                     (res[RES_W-1:SAMPLE_BITS-1] != '1);

    always_comb begin
        if (!ovf) begin
            sat_val = res[SAMPLE_BITS-1:0];
        end else if (res[RES_W-1]) begin
            sat_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            filtered_reg <= sat_val;
            clipped_reg  <= ovf;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = filtered_reg;
    assign m_clipped  = clipped_reg;
    assign stat.busy  = (state_reg != ST_IDLE);
    assign stat.load  = load;

endmodule

>>> rtl/fir_filter_circular_delay.sv
// top level of the direct-form fir filter over a circular delay line
//
// input channel s_*: each transfer carries either an audio sample (s_kind low)
// or one q1.15 coefficient write (s_kind high, s_tap_index, s_tap_value).
// result channel m_*: one transfer per sample with the rounded, saturated
// output and a clip flag; coefficient writes give no result.
// the apb port holds active_taps at byte address 0; the user must write it
// only while idle, which the block itself does not enforce. a two-entry queue
// sits behind the input, so up to two items are taken while the engine works
// on an earlier item or a result waits on m_ready. a sample is filtered by
// the single shared multiply-accumulate stepping through one tap per cycle;
// a coefficient write goes straight into the tap memory.
// if m_ready is low the finished result stays in the output register and
// the engine holds its next sample there until the transfer completes;
// once both queue entries are taken s_ready goes low.
// reset clears the delay line, the taps and the write pointer, and sets
// active_taps to the built tap count; queued items are dropped by reset.
module fir_filter_circular_delay #(
    parameter int MAX_TAPS    = fircd_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fircd_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_TAPS)
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fircd_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [fircd_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fircd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_kind,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample,
    input  logic        [IDX_W-1:0]                s_tap_index,
    input  logic signed [fircd_pkg::COEF_BITS-1:0] s_tap_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_filtered,
    output logic                                   m_clipped
);
    import fircd_pkg::*;

    localparam int AT_W = $clog2(MAX_TAPS + 1);

    logic [AT_W-1:0] active_taps_reg, active_taps_next;
    logic            cfg_wr;
    logic            sel_active;

    logic                          q_valid;
    logic                          q_ready;
    logic                          q_is_coef;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic        [IDX_W-1:0]       q_tap_index;
    logic signed [COEF_BITS-1:0]   q_tap_value;
    fircd_stat_t                   stat;

    assign pready     = 1'b1;
    assign sel_active = (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_TAPS);
    assign cfg_wr     = psel && penable && pwrite && pready && sel_active;
    assign prdata     = sel_active ? APB_DATA_W'(active_taps_reg) : '0;

    always_comb begin
        active_taps_next = active_taps_reg;
        if (cfg_wr) begin
            active_taps_next = pwdata[AT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_taps_reg <= AT_W'(MAX_TAPS);
        end else begin
            active_taps_reg <= active_taps_next;
        end
    end

    fircd_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_sample    (s_sample),
        .s_tap_index (s_tap_index),
        .s_tap_value (s_tap_value),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_is_coef   (q_is_coef),
        .q_sample    (q_sample),
        .q_tap_index (q_tap_index),
        .q_tap_value (q_tap_value)
    );

    fircd_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .active_taps (active_taps_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_is_coef   (q_is_coef),
        .q_sample    (q_sample),
        .q_tap_index (q_tap_index),
        .q_tap_value (q_tap_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_filtered  (m_filtered),
        .m_clipped   (m_clipped),
        .stat        (stat)
    );

    // a result only appears after the engine has finished a sample
    a_result_from_engine: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(stat.load))
        else $error("result raised without an engine load");

    // an engine load always presents a result next cycle
    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load |=> m_valid)
        else $error("engine load did not show a result");

    // a queued item waiting on a busy engine is not dropped
    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready) |=> q_valid)
        else $error("queued item lost while engine busy");

    // the engine leaves idle only by taking an item from the queue
    a_busy_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stat.busy) |-> $past(q_valid && q_ready))
        else $error("engine started without a queued item");

endmodule
